// File: src/spicrc_pkg.sv
`default_nettype none

package spicrc_pkg;

    // Largest number of data bytes in one register, and the value it is held to.
    localparam int MAX_DATA_BYTES = 4;
    localparam int LIMIT_HI       = (MAX_DATA_BYTES < 4) ? MAX_DATA_BYTES : 4;
    localparam int LIMIT_INT      = (LIMIT_HI < 1) ? 1 : LIMIT_HI;
    localparam logic [2:0] BYTE_LIMIT = 3'(LIMIT_INT);

    // Field widths of one transfer on each channel.
    localparam int ADDR_W  = 6;
    localparam int COUNT_W = 3;
    localparam int KIND_W  = 2;
    localparam int VALUE_W = 32;
    localparam int RX_W    = 40;
    localparam int BYTE_W  = 8;

    // Command byte followed by up to five received or sent bytes.
    localparam int SHIFT_W = BYTE_W + RX_W;

    // Read flag in the command byte.
    localparam logic [7:0] READ_FLAG = 8'h40;

    // Default generator: x^8 + x^2 + x + 1.
    localparam logic [7:0] POLY_RESET = 8'h07;

    // Configuration register indexes.
    localparam logic CFG_CRC_ENABLE = 1'b0;
    localparam logic CFG_CRC_POLY   = 1'b1;

    // Register access kinds.
    localparam logic [1:0] ACC_READ_ONLY  = 2'd1;
    localparam logic [1:0] ACC_WRITE_ONLY = 2'd2;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_CRC_ERR = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_read;
        logic invalid;
        logic last_step;
        logic crc_on;
        logic out_free;
    } t_dp_stat;

    // One byte through the CRC-8, most significant bit first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        logic       fb;
        c = crc_in;
        for (int b = 7; b >= 0; b--) begin
            fb = c[7] ^ data[b];
            c  = {c[6:0], 1'b0};
            if (fb) begin
                c = c ^ poly;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: src/spicrc_in_if.sv
`default_nettype none

interface spicrc_in_if;
    logic                             valid;
    logic                             ready;
    logic                             command;
    logic [spicrc_pkg::ADDR_W-1:0]    reg_address;
    logic [spicrc_pkg::COUNT_W-1:0]   byte_count;
    logic [spicrc_pkg::KIND_W-1:0]    access_kind;
    logic [spicrc_pkg::VALUE_W-1:0]   write_value;
    logic [spicrc_pkg::RX_W-1:0]      received_bytes;

    modport source (
        output valid, command, reg_address, byte_count, access_kind,
               write_value, received_bytes,
        input  ready
    );

    modport sink (
        input  valid, command, reg_address, byte_count, access_kind,
               write_value, received_bytes,
        output ready
    );
endinterface

`default_nettype wire

// File: src/spicrc_out_if.sv
`default_nettype none

interface spicrc_out_if;
    logic                             valid;
    logic                             ready;
    logic [spicrc_pkg::BYTE_W-1:0]    frame_byte;
    logic                             last_byte;
    logic [spicrc_pkg::VALUE_W-1:0]   read_value;
    logic [1:0]                       status;

    modport source (
        output valid, frame_byte, last_byte, read_value, status,
        input  ready
    );

    modport sink (
        input  valid, frame_byte, last_byte, read_value, status,
        output ready
    );
endinterface

`default_nettype wire

// File: src/spi_register_frame_crc8_codec.sv
// A write feeds the command byte and then each data byte through the CRC unit into the output
// register, then sends the CRC byte when CRC is on; a read feeds the command, data and CRC
// bytes through the CRC unit, then gives one result; a rejected access gives one result.
// One byte per cycle through the CRC unit; a write steps only while the output register is
// free, and output stalls hold every result. A new transfer is taken only when one is done.
// Reset is synchronous, active low: CRC off, polynomial 0x07, controller idle, output empty.
`default_nettype none

module spi_register_frame_crc8_codec (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [7:0] i_cfg_data,
    spicrc_in_if.sink       i_in,
    spicrc_out_if.source    o_out
);

    spicrc_pkg::t_dp_cmd  cmd;
    spicrc_pkg::t_dp_stat stat;
    logic                 in_ready;

    // Controller.
    spicrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Datapath with CRC unit and output register.
    spicrc_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_command        (i_in.command),
        .i_reg_address    (i_in.reg_address),
        .i_byte_count     (i_in.byte_count),
        .i_access_kind    (i_in.access_kind),
        .i_write_value    (i_in.write_value),
        .i_received_bytes (i_in.received_bytes),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_frame_byte     (o_out.frame_byte),
        .o_last_byte      (o_out.last_byte),
        .o_read_value     (o_out.read_value),
        .o_status         (o_out.status)
    );

    assign i_in.ready = in_ready;

endmodule

`default_nettype wire

// File: src/spicrc_ctrl.sv
`default_nettype none

module spicrc_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire spicrc_pkg::t_dp_stat i_stat,
    output spicrc_pkg::t_dp_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready, n_in_ready;

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        n_in_ready = r_in_ready;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_STEP;
                    n_in_ready = 1'b0;
                end
            end
            S_STEP: begin
                if (i_stat.invalid) begin
                    n_state = S_FINISH;
                end else if (i_stat.is_read || i_stat.out_free) begin
                    // A write sends each byte it feeds through the CRC.
                    o_cmd.step = 1'b1;
                    if (i_stat.last_step) begin
                        if (!i_stat.is_read && !i_stat.crc_on) begin
                            n_state    = S_IDLE;
                            n_in_ready = 1'b1;
                        end else begin
                            n_state = S_FINISH;
                        end
                    end
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                    n_in_ready   = 1'b1;
                end
            end
            default: begin
                n_state    = S_IDLE;
                n_in_ready = 1'b1;
            end
        endcase
    end

    // State and the registered ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= n_in_ready;
        end
    end

    assign o_in_ready = r_in_ready;

endmodule

`default_nettype wire

// File: src/spicrc_dp.sv
`default_nettype none

module spicrc_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Configuration writes.
    input  wire logic                               i_cfg_we,
    input  wire logic                               i_cfg_idx,
    input  wire logic [7:0]                         i_cfg_data,
    // Incoming item.
    input  wire logic                               i_command,
    input  wire logic [spicrc_pkg::ADDR_W-1:0]      i_reg_address,
    input  wire logic [spicrc_pkg::COUNT_W-1:0]     i_byte_count,
    input  wire logic [spicrc_pkg::KIND_W-1:0]      i_access_kind,
    input  wire logic [spicrc_pkg::VALUE_W-1:0]     i_write_value,
    input  wire logic [spicrc_pkg::RX_W-1:0]        i_received_bytes,
    // Controller link.
    input  wire spicrc_pkg::t_dp_cmd                i_cmd,
    output spicrc_pkg::t_dp_stat                    o_stat,
    // Result register.
    input  wire logic                               i_out_ready,
    output logic                                    o_out_valid,
    output logic [spicrc_pkg::BYTE_W-1:0]           o_frame_byte,
    output logic                                    o_last_byte,
    output logic [spicrc_pkg::VALUE_W-1:0]          o_read_value,
    output logic [1:0]                              o_status
);

    // Configuration registers.
    logic       r_crc_en;
    logic [7:0] r_poly;

    // Per-item working registers.
    logic                               r_is_read;
    logic                               r_invalid;
    logic [2:0]                         r_rem;
    logic [spicrc_pkg::SHIFT_W-1:0]     r_shift;
    logic [7:0]                         r_crc;
    logic [7:0]                         r_cmd;
    logic [spicrc_pkg::VALUE_W-1:0]     r_value;

    // Result register.
    logic                               r_ov;
    logic [7:0]                         r_frame;
    logic                               r_last;
    logic [spicrc_pkg::VALUE_W-1:0]     r_rval;
    spicrc_pkg::t_status                r_status;

    logic [2:0]                         count_sat;
    logic [2:0]                         n_rx;
    logic [7:0]                         cmd_byte;
    logic                               load_invalid;
    logic [spicrc_pkg::VALUE_W-1:0]     w_aligned;
    logic [spicrc_pkg::RX_W-1:0]        rx_aligned;
    logic [spicrc_pkg::VALUE_W-1:0]     rx_data;
    logic [spicrc_pkg::VALUE_W-1:0]     value_mask;
    logic [7:0]                         head_byte;
    logic                               out_free;

    // Hold the byte count to the supported range.
    always_comb begin
        if (i_byte_count == 3'd0) begin
            count_sat = 3'd1;
        end else if (i_byte_count > spicrc_pkg::BYTE_LIMIT) begin
            count_sat = spicrc_pkg::BYTE_LIMIT;
        end else begin
            count_sat = i_byte_count;
        end
    end

    // Frame layout at load time.
    always_comb begin
        n_rx         = count_sat + {2'b00, r_crc_en};
        cmd_byte     = i_command ? (spicrc_pkg::READ_FLAG | {2'b00, i_reg_address})
                                 : {2'b00, i_reg_address};
        load_invalid = (i_command && (i_access_kind == spicrc_pkg::ACC_WRITE_ONLY)) ||
                       (!i_command && (i_access_kind == spicrc_pkg::ACC_READ_ONLY));
        w_aligned    = i_write_value << {3'd4 - count_sat, 3'b000};
        rx_aligned   = i_received_bytes << {3'd5 - n_rx, 3'b000};
        rx_data      = r_crc_en ? i_received_bytes[39:8] : i_received_bytes[31:0];
        value_mask   = 32'hFFFF_FFFF >> {3'd4 - count_sat, 3'b000};
    end

    assign head_byte = r_shift[spicrc_pkg::SHIFT_W-1 -: 8];
    assign out_free  = !r_ov || i_out_ready;

    // Status to the controller.
    always_comb begin
        o_stat.is_read   = r_is_read;
        o_stat.invalid   = r_invalid;
        o_stat.last_step = (r_rem == 3'd1);
        o_stat.crc_on    = r_crc_en;
        o_stat.out_free  = out_free;
    end

    // Configuration and the result-valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_en <= 1'b0;
            r_poly   <= spicrc_pkg::POLY_RESET;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    spicrc_pkg::CFG_CRC_ENABLE: r_crc_en <= i_cfg_data[0];
                    spicrc_pkg::CFG_CRC_POLY:   r_poly   <= i_cfg_data;
                    default: ;
                endcase
            end
            if ((i_cmd.step && !r_is_read) || i_cmd.finish) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Item registers: load the frame, then one byte through the CRC per step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_read <= i_command;
            r_invalid <= load_invalid;
            r_crc     <= 8'h00;
            r_cmd     <= cmd_byte;
            r_value   <= rx_data & value_mask;
            if (i_command) begin
                r_rem   <= n_rx + 3'd1;
                r_shift <= {cmd_byte, rx_aligned};
            end else begin
                r_rem   <= count_sat + 3'd1;
                r_shift <= {cmd_byte, w_aligned, 8'h00};
            end
        end else if (i_cmd.step) begin
            r_crc   <= spicrc_pkg::crc8_byte(r_crc, head_byte, r_poly);
            r_shift <= r_shift << 8;
            r_rem   <= r_rem - 3'd1;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && !r_is_read) begin
            r_frame  <= head_byte;
            r_last   <= (r_rem == 3'd1) && !r_crc_en;
            r_rval   <= '0;
            r_status <= spicrc_pkg::ST_OK;
        end else if (i_cmd.finish) begin
            r_last <= 1'b1;
            if (r_invalid) begin
                r_frame  <= 8'h00;
                r_rval   <= '0;
                r_status <= spicrc_pkg::ST_INVALID;
            end else if (r_is_read) begin
                r_frame <= r_cmd;
                if (r_crc_en && (r_crc != 8'h00)) begin
                    r_rval   <= '0;
                    r_status <= spicrc_pkg::ST_CRC_ERR;
                end else begin
                    r_rval   <= r_value;
                    r_status <= spicrc_pkg::ST_OK;
                end
            end else begin
                r_frame  <= r_crc;
                r_rval   <= '0;
                r_status <= spicrc_pkg::ST_OK;
            end
        end
    end

    assign o_out_valid  = r_ov;
    assign o_frame_byte = r_frame;
    assign o_last_byte  = r_last;
    assign o_read_value = r_rval;
    assign o_status     = r_status;

endmodule

`default_nettype wire

// File: src/spicrc_chk.sv
`default_nettype none

module spicrc_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [7:0]  i_frame_byte,
    input wire logic        i_last_byte,
    input wire logic [31:0] i_read_value,
    input wire logic [1:0]  i_status
);

    // A stalled result holds its valid and its byte.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_frame_byte))
        else $error("stalled result changed");

    // Only one transaction is in flight at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while busy");

    // Error results always close the transaction.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != spicrc_pkg::ST_OK) |-> i_last_byte)
        else $error("error result without last marker");

    // A read value only comes with a clean, final result.
    a_value_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_read_value != 32'd0) |->
            i_last_byte && (i_status == spicrc_pkg::ST_OK))
        else $error("read value on a non-final or failed result");

endmodule

bind spi_register_frame_crc8_codec spicrc_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_frame_byte (o_out.frame_byte),
    .i_last_byte  (o_out.last_byte),
    .i_read_value (o_out.read_value),
    .i_status     (o_out.status)
);

`default_nettype wire

// File: sim/spi_register_frame_crc8_codec_tb.sv
module spi_register_frame_crc8_codec_tb;

    localparam int CLK_HALF       = 5;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int PHASE_ITEMS    = 33;

    // Direction and access kinds that the package leaves unnamed.
    localparam logic       CMD_WRITE      = 1'b0;
    localparam logic       CMD_READ       = 1'b1;
    localparam logic [1:0] ACC_READ_WRITE = 2'd0;
    localparam logic [1:0] ACC_UNUSED     = 2'd3;

    // One register access request as it enters the codec.
    typedef struct packed {
        logic                                command;
        logic [spicrc_pkg::ADDR_W-1:0]       addr;
        logic [spicrc_pkg::COUNT_W-1:0]      count;
        logic [spicrc_pkg::KIND_W-1:0]       kind;
        logic [spicrc_pkg::VALUE_W-1:0]      wval;
        logic [spicrc_pkg::RX_W-1:0]         rx;
    } t_access_req;

    // One frame byte or read status as it leaves the codec.
    typedef struct packed {
        logic [spicrc_pkg::BYTE_W-1:0]       frame_byte;
        logic                                last_byte;
        logic [spicrc_pkg::VALUE_W-1:0]      read_value;
        spicrc_pkg::t_status                 status;
    } t_frame_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic [7:0] i_cfg_data;

    spicrc_in_if  in_if();
    spicrc_out_if out_if();

    spi_register_frame_crc8_codec u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if.sink),
        .o_out      (out_if.source)
    );

    // Shadow copy of the codec registers, updated on every write.
    logic       crc_enabled;
    logic [7:0] crc_poly;

    t_frame_result expected_frames_q[$];
    int          mismatch_count;
    int          quiet_cycles;
    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;

    always #CLK_HALF i_clk = ~i_clk;

    // CRC-8 over one byte, MSB first, using the shadow polynomial.
    function automatic logic [7:0] crc8_next(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] acc;
        logic       feedback;
        acc = crc_in;
        for (int k = 7; k >= 0; k--) begin
            feedback = acc[7] ^ data[k];
            acc = acc << 1;
            if (feedback) begin
                acc = acc ^ crc_poly;
            end
        end
        return acc;
    endfunction

    // The byte count is held between one and the data byte limit.
    function automatic logic [2:0] clamp_count(input logic [2:0] count);
        if (count < 3'd1) begin
            return 3'd1;
        end
        if (count > spicrc_pkg::BYTE_LIMIT) begin
            return spicrc_pkg::BYTE_LIMIT;
        end
        return count;
    endfunction

    function automatic void queue_result(input logic [7:0] fb, input logic last,
                                         input logic [31:0] value,
                                         input spicrc_pkg::t_status st);
        t_frame_result r;
        r.frame_byte = fb;
        r.last_byte  = last;
        r.read_value = value;
        r.status     = st;
        expected_frames_q.push_back(r);
    endfunction

    // Work out every result that one accepted request causes.
    function automatic void predict_frame(input t_access_req req);
        logic [2:0]  cnt;
        logic [7:0]  cmd_byte;
        logic [7:0]  crc;
        logic [7:0]  data;
        logic [31:0] value;
        int          total;
        cnt   = clamp_count(req.count);
        total = int'(cnt) + (crc_enabled ? 1 : 0);
        value = '0;
        if (req.command == CMD_READ) begin
            cmd_byte = spicrc_pkg::READ_FLAG | {2'b00, req.addr};
            if (req.kind == spicrc_pkg::ACC_WRITE_ONLY) begin
                queue_result(8'h00, 1'b1, '0, spicrc_pkg::ST_INVALID);
            end else begin
                crc = crc8_next(8'h00, cmd_byte);
                for (int i = 0; i < total; i++) begin
                    data = 8'(req.rx >> (8 * (total - 1 - i)));
                    crc  = crc8_next(crc, data);
                    if (i < int'(cnt)) begin
                        value = {value[23:0], data};
                    end
                end
                if (crc_enabled && crc != 8'h00) begin
                    queue_result(cmd_byte, 1'b1, '0, spicrc_pkg::ST_CRC_ERR);
                end else begin
                    queue_result(cmd_byte, 1'b1, value, spicrc_pkg::ST_OK);
                end
            end
        end else begin
            cmd_byte = {2'b00, req.addr};
            if (req.kind == spicrc_pkg::ACC_READ_ONLY) begin
                queue_result(8'h00, 1'b1, '0, spicrc_pkg::ST_INVALID);
            end else begin
                crc = crc8_next(8'h00, cmd_byte);
                queue_result(cmd_byte, 1'b0, '0, spicrc_pkg::ST_OK);
                for (int i = 0; i < int'(cnt); i++) begin
                    data = 8'(req.wval >> (8 * (int'(cnt) - 1 - i)));
                    crc  = crc8_next(crc, data);
                    queue_result(data, !crc_enabled && i == int'(cnt) - 1, '0,
                                 spicrc_pkg::ST_OK);
                end
                if (crc_enabled) begin
                    queue_result(crc, 1'b1, '0, spicrc_pkg::ST_OK);
                end
            end
        end
    endfunction

    // Replace the low byte with the CRC that makes the read frame check out.
    function automatic logic [39:0] seal_read_bytes(input t_access_req req,
                                                    input logic [39:0] bytes);
        logic [2:0] cnt;
        logic [7:0] crc;
        cnt = clamp_count(req.count);
        crc = crc8_next(8'h00, spicrc_pkg::READ_FLAG | {2'b00, req.addr});
        for (int i = 0; i < int'(cnt); i++) begin
            crc = crc8_next(crc, 8'(bytes >> (8 * (int'(cnt) - i))));
        end
        return {bytes[39:8], crc};
    endfunction

    function automatic t_access_req make_request(input logic cmd, input logic [5:0] addr,
                                                 input logic [2:0] count,
                                                 input logic [1:0] kind,
                                                 input logic [31:0] wval,
                                                 input logic [39:0] rx);
        t_access_req req;
        req.command = cmd;
        req.addr    = addr;
        req.count   = count;
        req.kind    = kind;
        req.wval    = wval;
        req.rx      = rx;
        return req;
    endfunction

    // Offer one request, with random idle cycles first, and hold it until the transfer.
    task automatic send_request(input t_access_req req);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid          = 1'b1;
        in_if.command        = req.command;
        in_if.reg_address    = req.addr;
        in_if.byte_count     = req.count;
        in_if.access_kind    = req.kind;
        in_if.write_value    = req.wval;
        in_if.received_bytes = req.rx;
        @(posedge i_clk);
        while (!in_if.ready) begin
            @(posedge i_clk);
        end
        predict_frame(req);
        @(negedge i_clk);
        in_if.valid = 1'b0;
    endtask

    // Wait for every expected result, then let the block finish its work.
    task automatic settle_block();
        while (expected_frames_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_config(input logic idx, input logic [7:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == spicrc_pkg::CFG_CRC_ENABLE) begin
            crc_enabled = data[0];
        end else begin
            crc_poly = data;
        end
    endtask

    // Write frames with CRC off: address and value extremes, every count.
    task automatic test_write_frames();
        send_request(make_request(CMD_WRITE, 6'd0, 3'd0, ACC_READ_WRITE, 32'h0, '0));
        send_request(make_request(CMD_WRITE, 6'd63, 3'd4, spicrc_pkg::ACC_WRITE_ONLY,
                                  32'hFFFF_FFFF, '0));
        send_request(make_request(CMD_WRITE, 6'd21, 3'd7, ACC_UNUSED, 32'h1234_5678, '0));
        send_request(make_request(CMD_WRITE, 6'd42, 3'd2, ACC_READ_WRITE,
                                  32'hA5A5_5A5A, '1));
        send_request(make_request(CMD_WRITE, 6'd5, 3'd3, spicrc_pkg::ACC_WRITE_ONLY,
                                  32'h00C3_3C81, '0));
    endtask

    // Read frames with CRC off: the value is taken from the low bytes only.
    task automatic test_read_frames();
        send_request(make_request(CMD_READ, 6'd63, 3'd4, ACC_READ_WRITE, '0, '1));
        send_request(make_request(CMD_READ, 6'd0, 3'd0, spicrc_pkg::ACC_READ_ONLY, '1, '0));
        send_request(make_request(CMD_READ, 6'd33, 3'd6, ACC_UNUSED, '0,
                                  40'hDE_ADBE_EF01));
        send_request(make_request(CMD_READ, 6'd18, 3'd2, spicrc_pkg::ACC_READ_ONLY, '0,
                                  40'h12_3456_789A));
    endtask

    // A write to a read-only register and a read of a write-only one are refused.
    task automatic test_access_checks();
        send_request(make_request(CMD_WRITE, 6'd9, 3'd4, spicrc_pkg::ACC_READ_ONLY, '1, '0));
        send_request(make_request(CMD_READ, 6'd50, 3'd4, spicrc_pkg::ACC_WRITE_ONLY, '0, '1));
    endtask

    // CRC on with the default polynomial, then the all-one and all-zero polynomials.
    task automatic test_crc_frames();
        t_access_req req;
        settle_block();
        write_config(spicrc_pkg::CFG_CRC_ENABLE, 8'h01);
        send_request(make_request(CMD_WRITE, 6'd63, 3'd4, ACC_READ_WRITE, '1, '0));
        send_request(make_request(CMD_WRITE, 6'd1, 3'd1, spicrc_pkg::ACC_WRITE_ONLY,
                                  32'h0000_0080, '0));
        req = make_request(CMD_READ, 6'd12, 3'd4, ACC_READ_WRITE, '0, 40'h5A_C3F0_0F99);
        send_request(make_request(CMD_READ, req.addr, req.count, req.kind, '0,
                                  seal_read_bytes(req, req.rx)));
        // A single flipped bit in the CRC byte must be caught.
        send_request(make_request(CMD_READ, req.addr, req.count, req.kind, '0,
                                  seal_read_bytes(req, req.rx) ^ 40'h1));
        req = make_request(CMD_READ, 6'd63, 3'd1, spicrc_pkg::ACC_READ_ONLY, '0, '1);
        send_request(make_request(CMD_READ, req.addr, req.count, req.kind, '0,
                                  seal_read_bytes(req, req.rx)));
        settle_block();
        write_config(spicrc_pkg::CFG_CRC_POLY, 8'hFF);
        send_request(make_request(CMD_WRITE, 6'd30, 3'd4, ACC_READ_WRITE, 32'hCAFE_F00D, '0));
        req = make_request(CMD_READ, 6'd30, 3'd3, ACC_UNUSED, '0, 40'h00_1122_3344);
        send_request(make_request(CMD_READ, req.addr, req.count, req.kind, '0,
                                  seal_read_bytes(req, req.rx)));
        settle_block();
        write_config(spicrc_pkg::CFG_CRC_POLY, 8'h00);
        send_request(make_request(CMD_WRITE, 6'd7, 3'd2, ACC_READ_WRITE, 32'h0000_BEEF, '0));
        send_request(make_request(CMD_READ, 6'd7, 3'd2, ACC_READ_WRITE, '0, 40'h12_3456_789A));
    endtask

    // One random request: mostly legal directions, mostly valid CRC on reads.
    task automatic send_random_request();
        t_access_req req;
        int unsigned pick;
        req.command = 1'($urandom_range(1));
        req.addr    = 6'($urandom);
        if ($urandom_range(9) == 0) begin
            pick      = $urandom_range(3);
            req.count = (pick == 0) ? 3'd0 : 3'(4 + pick);
        end else begin
            req.count = 3'($urandom_range(4, 1));
        end
        pick = $urandom_range(2);
        if ($urandom_range(9) < 8) begin
            if (req.command == CMD_READ) begin
                req.kind = (pick == 2) ? ACC_UNUSED : 2'(pick);
            end else begin
                req.kind = (pick == 0) ? ACC_READ_WRITE :
                           (pick == 1) ? spicrc_pkg::ACC_WRITE_ONLY : ACC_UNUSED;
            end
        end else begin
            req.kind = (req.command == CMD_READ) ? spicrc_pkg::ACC_WRITE_ONLY :
                                                   spicrc_pkg::ACC_READ_ONLY;
        end
        req.wval = $urandom;
        req.rx   = {8'($urandom), 32'($urandom)};
        if (req.command == CMD_READ && crc_enabled && $urandom_range(3) != 0) begin
            req.rx = seal_read_bytes(req, req.rx);
        end
        send_request(req);
    endtask

    // Random traffic over several register settings and idle patterns.
    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++) begin
            settle_block();
            case (phase)
                0: begin
                    write_config(spicrc_pkg::CFG_CRC_ENABLE, 8'h00);
                    write_config(spicrc_pkg::CFG_CRC_POLY, spicrc_pkg::POLY_RESET);
                    src_idle_pct = 0;  snk_stall_pct = 0;
                end
                1: begin
                    write_config(spicrc_pkg::CFG_CRC_ENABLE, 8'h01);
                    write_config(spicrc_pkg::CFG_CRC_POLY, spicrc_pkg::POLY_RESET);
                    src_idle_pct = 70; snk_stall_pct = 0;
                end
                2: begin
                    write_config(spicrc_pkg::CFG_CRC_ENABLE, 8'hFF);
                    write_config(spicrc_pkg::CFG_CRC_POLY, 8'($urandom));
                    src_idle_pct = 0;  snk_stall_pct = 70;
                end
                3: begin
                    write_config(spicrc_pkg::CFG_CRC_ENABLE, 8'h01);
                    write_config(spicrc_pkg::CFG_CRC_POLY, 8'h00);
                    src_idle_pct = 29; snk_stall_pct = 29;
                end
                4: begin
                    write_config(spicrc_pkg::CFG_CRC_ENABLE, 8'h01);
                    write_config(spicrc_pkg::CFG_CRC_POLY, 8'hFF);
                    src_idle_pct = 70; snk_stall_pct = 0;
                end
                default: begin
                    write_config(spicrc_pkg::CFG_CRC_ENABLE, 8'($urandom_range(1)));
                    write_config(spicrc_pkg::CFG_CRC_POLY, 8'($urandom));
                    src_idle_pct = 29; snk_stall_pct = 29;
                end
            endcase
            repeat (PHASE_ITEMS) send_random_request();
        end
    endtask

    // The receiver stalls at random at every falling edge.
    always @(negedge i_clk) begin
        out_if.ready = ($urandom_range(99) >= snk_stall_pct);
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_frame_result exp_r;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_frames_q.size() == 0) begin
                $error("unexpected result: frame_byte %0h last_byte %0b %s %0h status %0d",
                       out_if.frame_byte, out_if.last_byte, "read_value",
                       out_if.read_value, out_if.status);
                mismatch_count++;
            end else begin
                exp_r = expected_frames_q.pop_front();
                if (out_if.frame_byte !== exp_r.frame_byte) begin
                    $error("frame_byte: expected %0h, got %0h", exp_r.frame_byte,
                           out_if.frame_byte);
                    mismatch_count++;
                end
                if (out_if.last_byte !== exp_r.last_byte) begin
                    $error("last_byte: expected %0b, got %0b", exp_r.last_byte,
                           out_if.last_byte);
                    mismatch_count++;
                end
                if (out_if.read_value !== exp_r.read_value) begin
                    $error("read_value: expected %0h, got %0h", exp_r.read_value,
                           out_if.read_value);
                    mismatch_count++;
                end
                if (out_if.status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, out_if.status);
                    mismatch_count++;
                end
            end
        end
    end

    // End the run when no transfer happens on either side for too long.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = spicrc_pkg::CFG_CRC_ENABLE;
        i_cfg_data           = 8'h00;
        in_if.valid          = 1'b0;
        in_if.command        = CMD_WRITE;
        in_if.reg_address    = '0;
        in_if.byte_count     = '0;
        in_if.access_kind    = ACC_READ_WRITE;
        in_if.write_value    = '0;
        in_if.received_bytes = '0;
        out_if.ready         = 1'b0;
        crc_enabled          = 1'b0;
        crc_poly             = spicrc_pkg::POLY_RESET;
        mismatch_count       = 0;
        quiet_cycles         = 0;
        src_idle_pct         = 0;
        snk_stall_pct        = 0;

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_write_frames();
        test_read_frames();
        test_access_checks();
        test_crc_frames();
        test_random_traffic();

        settle_block();
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: files.f
src/spicrc_pkg.sv
src/spicrc_in_if.sv
src/spicrc_out_if.sv
src/spicrc_ctrl.sv
src/spicrc_dp.sv
src/spi_register_frame_crc8_codec.sv
src/spicrc_chk.sv
sim/spi_register_frame_crc8_codec_tb.sv
